FILE: hw/rtl/bia_pkg.sv
// bia_pkg: sizes, command and status codes and sequencer states of the bitmap id allocator
// no dependencies; used by bia_scan, bitmap_id_allocator_core and the testbench
package bia_pkg;

	localparam int MAX_IDS   = 1024;
	localparam int WORD_BITS = 32;
	localparam int NWORDS    = MAX_IDS / WORD_BITS;
	localparam int ID_W      = $clog2(MAX_IDS);
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int WAD_W     = $clog2(NWORDS);
	localparam int CNT_W     = $clog2(NWORDS + 1);

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_CHECK = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FIRST,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] bit_idx;
	} scan_res_t;

endpackage

FILE: hw/rtl/bitmap_id_allocator_core.sv
// bitmap_id_allocator_core: top level of the next-fit bitmap id allocator
// depends on bia_pkg and bia_scan
//
// channel  dir  handshake              payload
// in       in   in_valid / in_stall    cmd, req_id
// out      out  out_valid / out_stall  granted_id, status, alive
//
// one command at a time: in_stall is high from the cycle after a transfer until the result
// has moved into the output register
// free and check read the addressed word, an unused command reads none; allocate ends on the
// start word when it has room and else walks on through all 32 bitmap words, one word a
// cycle through the single read port of the bitmap memory and the shared search unit
// reset clears the control state and the per-word valid bits at once: a word not written
// since reset reads as all free, so no clearing pass is needed
// a stalled result stays in the output register while the next command is taken
module bitmap_id_allocator_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                cmd,
	input  logic [bia_pkg::ID_W-1:0]  req_id,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [bia_pkg::ID_W-1:0]  granted_id,
	output logic [1:0]                status,
	output logic                      alive
);

	// sequencer
	bia_pkg::state_t state_q, state_d;

	// command being worked on
	logic [1:0]                 cmd_q;
	logic [bia_pkg::ID_W-1:0]   rid_q;
	logic [bia_pkg::WAD_W-1:0]  elem_q;
	logic [bia_pkg::BIT_W-1:0]  b_q;
	logic [bia_pkg::CNT_W-1:0]  k_q;
	logic [bia_pkg::ID_W-1:0]   lg_q;

	// bitmap memory, one row per word
	logic [bia_pkg::WORD_BITS-1:0] mem [bia_pkg::NWORDS];
	logic [bia_pkg::NWORDS-1:0]    row_vld_q;
	logic [bia_pkg::WORD_BITS-1:0] rdata_q;
	logic                          rvld_q;
	logic [bia_pkg::WAD_W-1:0]     rd_addr_q;
	logic [bia_pkg::WAD_W-1:0]     rd_addr;
	logic [bia_pkg::WORD_BITS-1:0] word;

	// write and result control
	logic                          we;
	logic [bia_pkg::WORD_BITS-1:0] wdata;
	logic                          res_ld;
	logic [bia_pkg::ID_W-1:0]      res_id_d;
	logic [1:0]                    res_st_d;
	logic                          res_alive_d;
	logic                          lg_ld;
	logic                          k_inc;
	logic                          k_first;

	logic [bia_pkg::ID_W-1:0]      res_id_q;
	logic [1:0]                    res_st_q;
	logic                          res_alive_q;

	// output register
	logic                          out_vld_q;
	logic [bia_pkg::ID_W-1:0]      out_id_q;
	logic [1:0]                    out_st_q;
	logic                          out_alive_q;
	logic                          out_ld;

	logic                          in_xfer;
	logic [bia_pkg::ID_W:0]        start_ext;
	logic [bia_pkg::ID_W-1:0]      start_id;
	logic [bia_pkg::BIT_W-1:0]     low_bit;
	logic [bia_pkg::BIT_W-1:0]     rid_bit;
	logic                          rid_used;
	bia_pkg::scan_res_t            scan;

	assign in_stall = (state_q != bia_pkg::S_IDLE);
	assign in_xfer  = in_valid && !in_stall;

	// next-fit start: one past the last grant, back to id 1 past the top
	assign start_ext = {1'b0, lg_q} + (bia_pkg::ID_W + 1)'(1);
	assign start_id  = (start_ext >= (bia_pkg::ID_W + 1)'(bia_pkg::MAX_IDS))
		? bia_pkg::ID_W'(1) : start_ext[bia_pkg::ID_W-1:0];

	// an untouched row reads as all free
	assign word = rvld_q ? rdata_q : '0;

	// only the start word is searched from the start bit upward
	assign low_bit = (state_q == bia_pkg::S_FIRST) ? b_q : '0;

	bia_scan u_scan (
		.word      (word),
		.word_addr (rd_addr_q),
		.low_bit   (low_bit),
		.res       (scan)
	);

	// free and check look at the requested bit; id 0 is never in use
	assign rid_bit  = rid_q[bia_pkg::BIT_W-1:0];
	assign rid_used = word[rid_bit] && (rid_q != '0);

	// read address: one word issued per cycle, its data is registered and used in the next cycle
	always_comb begin
		case (state_q)
			bia_pkg::S_IDLE: begin
				rd_addr = (cmd == bia_pkg::CMD_ALLOC)
					? start_id[bia_pkg::ID_W-1:bia_pkg::BIT_W]
					: req_id[bia_pkg::ID_W-1:bia_pkg::BIT_W];
			end
			bia_pkg::S_FIRST: rd_addr = elem_q + bia_pkg::WAD_W'(1);
			bia_pkg::S_SCAN: begin
				rd_addr = elem_q + k_q[bia_pkg::WAD_W-1:0] + bia_pkg::WAD_W'(1);
			end
			default: rd_addr = rd_addr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[rd_addr_q] <= wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rvld_q    <= 1'b0;
		end else begin
			if (we) begin
				row_vld_q[rd_addr_q] <= 1'b1;
			end
			rvld_q <= row_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_q <= rd_addr;
	end

	// sequencer register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bia_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, bitmap write and result
	always_comb begin
		state_d     = state_q;
		we          = 1'b0;
		wdata       = word;
		res_ld      = 1'b0;
		res_id_d    = '0;
		res_st_d    = bia_pkg::ST_OK;
		res_alive_d = 1'b0;
		lg_ld       = 1'b0;
		k_inc       = 1'b0;
		k_first     = 1'b0;
		out_ld      = 1'b0;
		case (state_q)
			bia_pkg::S_IDLE: begin
				if (in_xfer) begin
					res_ld = 1'b1;
					if (cmd inside {bia_pkg::CMD_ALLOC, bia_pkg::CMD_FREE,
							bia_pkg::CMD_CHECK}) begin
						state_d = bia_pkg::S_FIRST;
					end else begin
						res_st_d = bia_pkg::ST_BAD;
						state_d  = bia_pkg::S_DONE;
					end
				end
			end
			bia_pkg::S_FIRST: begin
				case (cmd_q)
					bia_pkg::CMD_ALLOC: begin
						if (scan.found) begin
							we       = 1'b1;
							wdata    = word | (bia_pkg::WORD_BITS'(1) << scan.bit_idx);
							res_ld   = 1'b1;
							res_id_d = {rd_addr_q, scan.bit_idx};
							lg_ld    = 1'b1;
							state_d  = bia_pkg::S_DONE;
						end else begin
							k_first = 1'b1;
							state_d = bia_pkg::S_SCAN;
						end
					end
					bia_pkg::CMD_FREE: begin
						res_ld = 1'b1;
						if (rid_used) begin
							we    = 1'b1;
							wdata = word & ~(bia_pkg::WORD_BITS'(1) << rid_bit);
						end else begin
							res_st_d = bia_pkg::ST_BAD;
						end
						state_d = bia_pkg::S_DONE;
					end
					default: begin
						res_ld      = 1'b1;
						res_alive_d = rid_used;
						state_d     = bia_pkg::S_DONE;
					end
				endcase
			end
			bia_pkg::S_SCAN: begin
				if (scan.found) begin
					we       = 1'b1;
					wdata    = word | (bia_pkg::WORD_BITS'(1) << scan.bit_idx);
					res_ld   = 1'b1;
					res_id_d = {rd_addr_q, scan.bit_idx};
					lg_ld    = 1'b1;
					state_d  = bia_pkg::S_DONE;
				end else if (k_q == bia_pkg::CNT_W'(bia_pkg::NWORDS)) begin
					// every word walked, start word included in full
					res_ld   = 1'b1;
					res_st_d = bia_pkg::ST_FULL;
					state_d  = bia_pkg::S_DONE;
				end else begin
					k_inc = 1'b1;
				end
			end
			bia_pkg::S_DONE: begin
				if (!out_vld_q || !out_stall) begin
					out_ld  = 1'b1;
					state_d = bia_pkg::S_IDLE;
				end
			end
			default: state_d = bia_pkg::S_IDLE;
		endcase
	end

	// command registers and search counter
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q  <= cmd;
			rid_q  <= req_id;
			elem_q <= start_id[bia_pkg::ID_W-1:bia_pkg::BIT_W];
			b_q    <= start_id[bia_pkg::BIT_W-1:0];
		end
		if (k_first) begin
			k_q <= bia_pkg::CNT_W'(1);
		end else if (k_inc) begin
			k_q <= k_q + bia_pkg::CNT_W'(1);
		end
		if (res_ld) begin
			res_id_q    <= res_id_d;
			res_st_q    <= res_st_d;
			res_alive_q <= res_alive_d;
		end
		if (out_ld) begin
			out_id_q    <= res_id_q;
			out_st_q    <= res_st_q;
			out_alive_q <= res_alive_q;
		end
	end

	// last grant, start of the next search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q <= '0;
		end else if (lg_ld) begin
			lg_q <= res_id_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_ld) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_valid  = out_vld_q;
	assign granted_id = out_id_q;
	assign status     = out_st_q;
	assign alive      = out_alive_q;

endmodule

FILE: hw/rtl/bia_scan.sv
// bia_scan: shared search unit, finds the lowest grantable free bit of one bitmap word
// depends on bia_pkg
module bia_scan (
	input  logic [bia_pkg::WORD_BITS-1:0] word,
	input  logic [bia_pkg::WAD_W-1:0]     word_addr,
	input  logic [bia_pkg::BIT_W-1:0]     low_bit,
	output bia_pkg::scan_res_t            res
);

	logic [bia_pkg::WORD_BITS-1:0] free_bits;

	// free, at or above the lower bound, and never id 0
	always_comb begin
		for (int i = 0; i < bia_pkg::WORD_BITS; i++) begin
			free_bits[i] = !word[i] && (bia_pkg::BIT_W'(i) >= low_bit)
				&& !(word_addr == '0 && i == 0);
		end
	end

	// priority encode, lowest index wins
	always_comb begin
		res.found   = |free_bits;
		res.bit_idx = '0;
		for (int i = bia_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				res.bit_idx = bia_pkg::BIT_W'(i);
			end
		end
	end

endmodule

FILE: tb/bitmap_id_allocator_checker.sv
`timescale 1ns / 1ps
// bitmap_id_allocator_checker: watches both channels of the id allocator, predicts each result
// and compares it field by field; depends on bia_pkg only
module bitmap_id_allocator_checker
	import bia_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_stall,
	input  logic [1:0]      cmd,
	input  logic [ID_W-1:0] req_id,
	input  logic            out_valid,
	input  logic            out_stall,
	input  logic [ID_W-1:0] granted_id,
	input  logic [1:0]      status,
	input  logic            alive,
	output int              pending,
	output int              errors
);

	typedef struct packed {
		logic [1:0]      op;
		logic [ID_W-1:0] id;
		logic [1:0]      st;
		logic            live;
	} grant_result_t;

	logic [WORD_BITS-1:0] used_map [NWORDS];
	logic [ID_W-1:0]      last_grant;
	grant_result_t        result_q [$];
	int                   mismatch_cnt;

	// free bits of a word that may be handed out
	function automatic logic [WORD_BITS-1:0] free_bits(input int w);
		logic [WORD_BITS-1:0] f;
		int id;
		f = ~used_map[w];
		for (int i = 0; i < WORD_BITS; i++) begin
			id = w * WORD_BITS + i;
			if (id == 0 || id >= MAX_IDS)
				f[i] = 1'b0;
		end
		return f;
	endfunction

	function automatic int lowest_set(input logic [WORD_BITS-1:0] f);
		int pos;
		pos = 0;
		for (int i = WORD_BITS - 1; i >= 0; i--)
			if (f[i])
				pos = i;
		return pos;
	endfunction

	function automatic logic is_used(input logic [ID_W-1:0] id);
		if (id == '0 || int'(id) >= MAX_IDS)
			return 1'b0;
		return used_map[id / WORD_BITS][id % WORD_BITS];
	endfunction

	// next-fit search: rest of the last word first, then whole words round-robin
	task automatic predict_result(input logic [1:0] c, input logic [ID_W-1:0] rid,
		output grant_result_t r);
		int start, word, bitpos, n;
		logic [WORD_BITS-1:0] f;
		logic hit;
		r = '0;
		r.op = c;
		r.st = ST_OK;
		case (c)
			CMD_ALLOC: begin
				start = int'(last_grant) + 1;
				if (start >= MAX_IDS)
					start = 1;
				word = start / WORD_BITS;
				f = free_bits(word) & ({WORD_BITS{1'b1}} << (start % WORD_BITS));
				hit = (f != '0);
				for (int k = 1; k <= NWORDS && !hit; k++) begin
					n = (word + k) % NWORDS;
					f = free_bits(n);
					if (f != '0) begin
						word = n;
						hit = 1'b1;
					end
				end
				if (hit) begin
					bitpos = lowest_set(f);
					used_map[word][bitpos] = 1'b1;
					last_grant = ID_W'(word * WORD_BITS + bitpos);
					r.id = last_grant;
				end else begin
					r.st = ST_FULL;
				end
			end
			CMD_FREE: begin
				if (is_used(rid))
					used_map[rid / WORD_BITS][rid % WORD_BITS] = 1'b0;
				else
					r.st = ST_BAD;
			end
			CMD_CHECK: begin
				r.live = is_used(rid);
			end
			default: begin
				r.st = ST_BAD;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_result_t want;
		if (!arst_n) begin
			for (int w = 0; w < NWORDS; w++)
				used_map[w] = '0;
			last_grant = '0;
			result_q.delete();
			mismatch_cnt = 0;
			pending <= 0;
			errors <= 0;
		end else begin
			// results first: a result always belongs to an earlier command
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: result with nothing expected: id %0d status %0d alive %0d",
							$realtime, granted_id, status, alive);
				end else begin
					want = result_q.pop_front();
					if (granted_id !== want.id || status !== want.st || alive !== want.live) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display({"%0t: mismatch on cmd %0d: expected id %0d status %0d ",
								"alive %0d, got id %0d status %0d alive %0d"}, $realtime,
								want.op, want.id, want.st, want.live, granted_id, status, alive);
					end
				end
			end
			if (in_valid && !in_stall) begin
				predict_result(cmd, req_id, want);
				result_q.push_back(want);
			end
			pending <= result_q.size();
			errors <= mismatch_cnt;
		end
	end

endmodule

FILE: tb/bitmap_id_allocator_core_test.sv
`timescale 1ns / 1ps
// bitmap_id_allocator_core_test: stimulus and verdict for the bitmap id allocator
// depends on bia_pkg, bitmap_id_allocator_core and bitmap_id_allocator_checker
module bitmap_id_allocator_core_test;
	import bia_pkg::*;

	// the one code the package leaves unnamed
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// cycles without any transfer before the run is declared hung
	localparam int IDLE_LIMIT = 2000;
	// cycles to wait after the last result has come
	localparam int TAIL_CYCLES = 40;

	typedef enum logic [1:0] {
		RX_FLOW,
		RX_RANDOM,
		RX_LONG
	} rx_mode_t;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            in_valid;
	logic            in_stall;
	logic [1:0]      cmd;
	logic [ID_W-1:0] req_id;
	logic            out_valid;
	logic            out_stall = 1'b0;
	logic [ID_W-1:0] granted_id;
	logic [1:0]      status;
	logic            alive;

	int              pending;
	int              errors;

	// ids seen granted and not yet picked for a free
	logic [ID_W-1:0] live_ids [$];
	// sender burst bookkeeping
	int              burst_left = 0;
	// receiver stall pattern
	rx_mode_t        rx_mode = RX_FLOW;
	logic [7:0]      rx_cycle = '0;
	int              stall_run = 0;
	// watchdog
	int              idle_cycles = 0;

	bitmap_id_allocator_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.req_id     (req_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.granted_id (granted_id),
		.status     (status),
		.alive      (alive)
	);

	bitmap_id_allocator_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.req_id     (req_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.granted_id (granted_id),
		.status     (status),
		.alive      (alive),
		.pending    (pending),
		.errors     (errors)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one command transfer; a new burst starts after a gap with valid low,
	// inside a burst valid stays high and only the payload moves on
	task automatic issue(input logic [1:0] c, input logic [ID_W-1:0] id);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 20);
			// mostly short bursts, now and then a long one with no idling at all
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		cmd <= c;
		req_id <= id;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// an id for free or check: a granted one with the given odds, else any 10-bit value
	task automatic pick_id(input int live_pct, input logic take, output logic [ID_W-1:0] id);
		int idx;
		if (live_ids.size() > 0 && $urandom_range(0, 99) < live_pct) begin
			idx = $urandom_range(0, live_ids.size() - 1);
			id = live_ids[idx];
			if (take)
				live_ids.delete(idx);
		end else begin
			id = ID_W'($urandom_range(0, MAX_IDS - 1));
		end
	endtask

	// mixed traffic; alloc_pct sets how hard the bitmap is pushed toward full
	task automatic random_cmd(input int alloc_pct);
		int r;
		logic [ID_W-1:0] id;
		r = $urandom_range(0, 99);
		if (r < alloc_pct) begin
			// req_id is ignored on allocate, so it carries noise
			issue(CMD_ALLOC, ID_W'($urandom));
		end else if (r < alloc_pct + 30) begin
			pick_id(80, 1'b1, id);
			issue(CMD_FREE, id);
		end else if (r < 95) begin
			pick_id(50, 1'b0, id);
			issue(CMD_CHECK, id);
		end else begin
			issue(CMD_UNUSED, ID_W'($urandom));
		end
	endtask

	// hold the sender until the checker has nothing outstanding
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	initial begin
		logic [ID_W-1:0] id;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_ALLOC;
		req_id = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: invalid ids, bad frees, unused command, first grants,
		// double free and next-fit skipping a freed id
		issue(CMD_CHECK, '0);
		issue(CMD_CHECK, '1);
		issue(CMD_FREE, '0);
		issue(CMD_FREE, '1);
		issue(CMD_FREE, ID_W'(512));
		issue(CMD_UNUSED, '1);
		issue(CMD_UNUSED, '0);
		issue(CMD_ALLOC, '1);
		issue(CMD_ALLOC, '0);
		issue(CMD_ALLOC, ID_W'(700));
		issue(CMD_CHECK, ID_W'(2));
		issue(CMD_FREE, ID_W'(2));
		issue(CMD_FREE, ID_W'(2));
		issue(CMD_CHECK, ID_W'(2));
		issue(CMD_ALLOC, '0);
		issue(CMD_ALLOC, '0);
		issue(CMD_FREE, ID_W'(1));
		issue(CMD_CHECK, '1);
		issue(CMD_CHECK, ID_W'(1));
		drain();

		// fill the whole bitmap: the search walks up to the top id, wraps past
		// id zero and finally runs dry, which gives a string of exhaustion results;
		// a check now and then, few enough that the allocates still fill every id
		for (int i = 0; i < 1045; i++) begin
			if (i % 64 == 63) begin
				pick_id(50, 1'b0, id);
				issue(CMD_CHECK, id);
			end else begin
				issue(CMD_ALLOC, ID_W'($urandom));
			end
		end

		// near full: scattered frees make allocate scan many full words
		for (int i = 0; i < 40; i++)
			random_cmd(45);
		drain();

		// a batch of frees, mostly of granted ids
		for (int i = 0; i < 30; i++) begin
			pick_id(95, 1'b1, id);
			issue(CMD_FREE, id);
		end

		// mixed traffic after the frees
		for (int i = 0; i < 40; i++)
			random_cmd(40);

		// end of stimulus: wait for the last result, then a short tail
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: the stall pattern switches mode each time the 8-bit rx_cycle counter wraps
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1'b1;
		if (rx_cycle == '0)
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
		if (stall_run != 0) begin
			// long stall in progress, out_stall stays high
			stall_run <= stall_run - 1;
		end else begin
			case (rx_mode)
				RX_FLOW: begin
					out_stall <= 1'b0;
				end
				RX_RANDOM: begin
					out_stall <= 1'($urandom_range(0, 1));
				end
				default: begin
					if ($urandom_range(0, 7) == 0) begin
						out_stall <= 1'b1;
						stall_run <= $urandom_range(1, 15);
					end else begin
						out_stall <= 1'b0;
					end
				end
			endcase
		end
	end

	// collect granted ids so that frees and checks can hit live ones
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall && status == ST_OK && granted_id != '0)
			live_ids.push_back(granted_id);
	end

	// watchdog: any transfer on either channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

FILE: sim.f
hw/rtl/bia_pkg.sv
hw/rtl/bia_scan.sv
hw/rtl/bitmap_id_allocator_core.sv
tb/bitmap_id_allocator_checker.sv
tb/bitmap_id_allocator_core_test.sv
